[hw/rtl/rfirq_pkg.sv]
// Shared types, codes and default sizes for the register file, interrupt and serial FIFO block.
`timescale 1ns / 1ps

package rfirq_pkg;

   localparam int REQ_CODE_W = 3;
   localparam int INDEX_W    = 6;
   localparam int VALUE_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int LEVEL_W    = 8;
   localparam int IRQ_BIT_W  = 4;

   localparam int NUM_REGS_DEFAULT      = 64;
   localparam int FIFO_DEPTH_DEFAULT    = 256;
   localparam int ENABLE_INDEX_DEFAULT  = 1;
   localparam int PENDING_INDEX_DEFAULT = 2;
   localparam int CLEAR_INDEX_DEFAULT   = 3;
   localparam int CONSOLE_INDEX_DEFAULT = 4;

   // Index compares are made at this width so that every index parameter and
   // the file size itself fit.
   localparam int WIDE_INDEX_W = 9;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [REQ_CODE_W-1:0] {
      REQ_READ     = 3'd0,
      REQ_WRITE    = 3'd1,
      REQ_POP_RX   = 3'd2,
      REQ_PUSH_TX  = 3'd3,
      REQ_INJECT   = 3'd4,
      REQ_DRAIN_TX = 3'd5,
      REQ_RAISE    = 3'd6,
      REQ_CONSOLE  = 3'd7
   } req_code_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_READ,
      OP_WRITE_FILE,
      OP_CLEAR,
      OP_POP_RX,
      OP_PUSH_TX,
      OP_INJECT_RX,
      OP_DRAIN_TX,
      OP_RAISE,
      OP_CONSOLE
   } op_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_FILE,
      RD_CONSOLE,
      RD_PENDING
   } rd_src_type;

   typedef enum logic {
      BK_IDLE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [REQ_CODE_W-1:0] req_type;
      logic [INDEX_W-1:0]    reg_index;
      logic [VALUE_W-1:0]    write_value;
      logic [BYTE_W-1:0]     byte_in;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_data;
      logic [BYTE_W-1:0]  byte_out;
      logic               ok;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
      logic               irq_line;
   } rsp_item_type;

   typedef struct packed {
      op_type             op;
      rd_src_type         rd_src;
      logic               wr_enable;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic [BYTE_W-1:0]  data_byte;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

[hw/rtl/rfirq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rfirq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hw/rtl/rfirq_front.sv]
// Front end: takes requests and sorts them into commands for the back end.
`timescale 1ns / 1ps

module rfirq_front import rfirq_pkg::*; #(
   parameter int NUM_REGS      = NUM_REGS_DEFAULT,
   parameter int ENABLE_INDEX  = ENABLE_INDEX_DEFAULT,
   parameter int PENDING_INDEX = PENDING_INDEX_DEFAULT,
   parameter int CLEAR_INDEX   = CLEAR_INDEX_DEFAULT,
   parameter int CONSOLE_INDEX = CONSOLE_INDEX_DEFAULT
) (
   input  logic         start,
   input  req_item_type req,
   input  q_status_type q_status,
   output logic         busy,
   output logic         push,
   output cmd_type      cmd
);

   logic [WIDE_INDEX_W-1:0] idx_wide;
   logic in_file;
   logic is_enable;
   logic is_pending;
   logic is_clear;
   logic is_console;

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   assign idx_wide   = WIDE_INDEX_W'(req.reg_index);
   assign in_file    = idx_wide < WIDE_INDEX_W'(NUM_REGS);
   assign is_enable  = idx_wide == WIDE_INDEX_W'(ENABLE_INDEX);
   assign is_pending = idx_wide == WIDE_INDEX_W'(PENDING_INDEX);
   assign is_clear   = idx_wide == WIDE_INDEX_W'(CLEAR_INDEX);
   assign is_console = idx_wide == WIDE_INDEX_W'(CONSOLE_INDEX);

   always_comb begin
      cmd.op        = OP_NONE;
      cmd.rd_src    = RD_ZERO;
      cmd.wr_enable = 1'b0;
      cmd.index     = req.reg_index;
      cmd.value     = req.write_value;
      cmd.data_byte = req.byte_in;
      unique case (req_code_type'(req.req_type))
         REQ_READ: begin
            cmd.op = OP_READ;
            priority if (is_console) begin
               cmd.rd_src = RD_CONSOLE;
            end else if (is_pending) begin
               cmd.rd_src = RD_PENDING;
            end else if (in_file) begin
               cmd.rd_src = RD_FILE;
            end else begin
               cmd.rd_src = RD_ZERO;
            end
         end
         REQ_WRITE: begin
            // The clear index takes precedence; the console word is read-only.
            priority if (is_clear) begin
               cmd.op = OP_CLEAR;
            end else if (!is_console && in_file) begin
               cmd.op        = OP_WRITE_FILE;
               cmd.wr_enable = is_enable;
            end else begin
               cmd.op = OP_NONE;
            end
         end
         REQ_POP_RX:   cmd.op = OP_POP_RX;
         REQ_PUSH_TX:  cmd.op = OP_PUSH_TX;
         REQ_INJECT:   cmd.op = OP_INJECT_RX;
         REQ_DRAIN_TX: cmd.op = OP_DRAIN_TX;
         REQ_RAISE:    cmd.op = OP_RAISE;
         REQ_CONSOLE:  cmd.op = OP_CONSOLE;
      endcase
   end

endmodule

[hw/rtl/rfirq_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module rfirq_queue import rfirq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_data,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head               = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = count_ff != '0;
   assign q_status.full      = count_ff == QCNT_W'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/rfirq_back.sv]
// Back end: register file, interrupt state and the two byte FIFOs.
`timescale 1ns / 1ps

module rfirq_back import rfirq_pkg::*; #(
   parameter int NUM_REGS   = NUM_REGS_DEFAULT,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  q_status_type         q_status,
   input  cmd_type              head,
   output logic                 pop,
   input  logic                 csr_we,
   input  logic [IRQ_BIT_W-1:0] csr_wdata,
   output logic                 rsp_strobe,
   output rsp_item_type         rsp
);

   localparam int RAW   = $clog2(NUM_REGS);
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

   back_state_type state_ff, state_in;
   logic issue;

   cmd_type cmd_ff, cmd_in;
   logic    ok_ff, ok_in;
   logic    file_hit_ff, file_hit_in;

   logic [NUM_REGS-1:0]  valid_ff, valid_in;
   logic [VALUE_W-1:0]   pending_ff, pending_in;
   logic [VALUE_W-1:0]   console_ff, console_in;
   logic [VALUE_W-1:0]   enable_ff, enable_in;
   logic [IRQ_BIT_W-1:0] rx_irq_bit_ff, rx_irq_bit_in;

   logic [PTR_W-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in, rx_count_ff, rx_count_in;
   logic [PTR_W-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in, tx_count_ff, tx_count_in;

   logic [RAW-1:0]     reg_addr;
   logic               reg_we;
   logic [VALUE_W-1:0] reg_q;
   logic               rx_we, rx_pop, tx_we, tx_pop;
   logic [BYTE_W-1:0]  rx_q, tx_q;
   logic [VALUE_W-1:0] enabled_pending;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   // Sequencer: issue a command and its memory accesses, then present the result.
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) begin
               pop      = 1'b1;
               issue    = 1'b1;
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_strobe = state_ff == BK_DONE;

   assign reg_addr = RAW'(head.index);
   assign reg_we   = issue && (head.op == OP_WRITE_FILE);
   assign rx_we    = issue && (head.op == OP_INJECT_RX) && (rx_count_ff != LAST);
   assign rx_pop   = issue && (head.op == OP_POP_RX) && (rx_count_ff != '0);
   assign tx_we    = issue && (head.op == OP_PUSH_TX) && (tx_count_ff != LAST);
   assign tx_pop   = issue && (head.op == OP_DRAIN_TX) && (tx_count_ff != '0);

   always_comb begin
      cmd_in        = cmd_ff;
      ok_in         = ok_ff;
      file_hit_in   = file_hit_ff;
      valid_in      = valid_ff;
      pending_in    = pending_ff;
      console_in    = console_ff;
      enable_in     = enable_ff;
      rx_irq_bit_in = csr_we ? csr_wdata : rx_irq_bit_ff;
      rx_wp_in      = rx_we ? advance(rx_wp_ff) : rx_wp_ff;
      rx_rp_in      = rx_pop ? advance(rx_rp_ff) : rx_rp_ff;
      tx_wp_in      = tx_we ? advance(tx_wp_ff) : tx_wp_ff;
      tx_rp_in      = tx_pop ? advance(tx_rp_ff) : tx_rp_ff;
      rx_count_in   = rx_count_ff + PTR_W'(rx_we) - PTR_W'(rx_pop);
      tx_count_in   = tx_count_ff + PTR_W'(tx_we) - PTR_W'(tx_pop);
      if (issue) begin
         cmd_in      = head;
         ok_in       = rx_we || rx_pop || tx_we || tx_pop;
         file_hit_in = valid_ff[reg_addr];
         if (reg_we) begin
            valid_in[reg_addr] = 1'b1;
         end
         if (head.wr_enable) begin
            enable_in = head.value;
         end
         priority if (head.op == OP_CLEAR) begin
            pending_in = pending_ff & ~head.value;
         end else if (head.op == OP_RAISE) begin
            pending_in = pending_ff | head.value;
         end else if (rx_we) begin
            pending_in = pending_ff | (VALUE_W'(1) << rx_irq_bit_ff);
         end else begin
            pending_in = pending_ff;
         end
         if (head.op == OP_CONSOLE) begin
            console_in = head.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         cmd_ff        <= '0;
         ok_ff         <= 1'b0;
         file_hit_ff   <= 1'b0;
         valid_ff      <= '0;
         pending_ff    <= '0;
         console_ff    <= '0;
         enable_ff     <= '0;
         rx_irq_bit_ff <= '0;
         rx_wp_ff      <= '0;
         rx_rp_ff      <= '0;
         rx_count_ff   <= '0;
         tx_wp_ff      <= '0;
         tx_rp_ff      <= '0;
         tx_count_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         ok_ff         <= ok_in;
         file_hit_ff   <= file_hit_in;
         valid_ff      <= valid_in;
         pending_ff    <= pending_in;
         console_ff    <= console_in;
         enable_ff     <= enable_in;
         rx_irq_bit_ff <= rx_irq_bit_in;
         rx_wp_ff      <= rx_wp_in;
         rx_rp_ff      <= rx_rp_in;
         rx_count_ff   <= rx_count_in;
         tx_wp_ff      <= tx_wp_in;
         tx_rp_ff      <= tx_rp_in;
         tx_count_ff   <= tx_count_in;
      end
   end

   // Entries never written read as zero through the valid bits.
   rfirq_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_REGS)) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_addr),
      .wr_data (head.value),
      .rd_addr (reg_addr),
      .rd_data (reg_q)
   );

   rfirq_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wp_ff),
      .wr_data (head.data_byte),
      .rd_addr (rx_rp_ff),
      .rd_data (rx_q)
   );

   rfirq_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wp_ff),
      .wr_data (head.data_byte),
      .rd_addr (tx_rp_ff),
      .rd_data (tx_q)
   );

   assign enabled_pending = pending_ff & enable_ff;

   always_comb begin
      rsp.read_data = '0;
      unique case (cmd_ff.rd_src)
         RD_ZERO:    rsp.read_data = '0;
         RD_FILE:    rsp.read_data = file_hit_ff ? reg_q : '0;
         RD_CONSOLE: rsp.read_data = console_ff;
         RD_PENDING: rsp.read_data = enabled_pending;
      endcase
      priority if (ok_ff && (cmd_ff.op == OP_POP_RX)) begin
         rsp.byte_out = rx_q;
      end else if (ok_ff && (cmd_ff.op == OP_DRAIN_TX)) begin
         rsp.byte_out = tx_q;
      end else begin
         rsp.byte_out = '0;
      end
      rsp.ok       = ok_ff;
      rsp.rx_level = LEVEL_W'(rx_count_ff);
      rsp.tx_level = LEVEL_W'(tx_count_ff);
      rsp.irq_line = enabled_pending != '0;
   end

endmodule

[hw/rtl/register_file_w1c_irq_sio_fifo_core.sv]
// With the back end free, an accepted request is written into the queue, issued from its head
// and registered in the back end, which shows the result at its finish step. The back end
// alternates its issue and finish steps around the registered read of the register and FIFO
// RAMs, taking no new command before the last is done; a two-entry queue absorbs bursts.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is synchronous; it clears control state, FIFO pointers and register valid bits at once,
// so no clearing pass is needed and unwritten registers read as zero.
`timescale 1ns / 1ps

module register_file_w1c_irq_sio_fifo_core import rfirq_pkg::*; #(
   parameter int NUM_REGS      = NUM_REGS_DEFAULT,
   parameter int FIFO_DEPTH    = FIFO_DEPTH_DEFAULT,
   parameter int ENABLE_INDEX  = ENABLE_INDEX_DEFAULT,
   parameter int PENDING_INDEX = PENDING_INDEX_DEFAULT,
   parameter int CLEAR_INDEX   = CLEAR_INDEX_DEFAULT,
   parameter int CONSOLE_INDEX = CONSOLE_INDEX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_payload,
   output logic                 rsp_strobe,
   output rsp_item_type         rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IRQ_BIT_W-1:0] csr_data
);

   q_status_type q_status;
   cmd_type      front_cmd;
   cmd_type      head;
   logic         push;
   logic         pop;

   assign csr_ready = 1'b1;

   rfirq_front #(
      .NUM_REGS      (NUM_REGS),
      .ENABLE_INDEX  (ENABLE_INDEX),
      .PENDING_INDEX (PENDING_INDEX),
      .CLEAR_INDEX   (CLEAR_INDEX),
      .CONSOLE_INDEX (CONSOLE_INDEX)
   ) u_front (
      .start    (start),
      .req      (req_payload),
      .q_status (q_status),
      .busy     (busy),
      .push     (push),
      .cmd      (front_cmd)
   );

   rfirq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   rfirq_back #(
      .NUM_REGS   (NUM_REGS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .csr_we     (csr_valid && csr_ready),
      .csr_wdata  (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );

endmodule

[hw/rtl/rfirq_checker.sv]
// Port-level checks on the block's timing, bound to the top level.
`timescale 1ns / 1ps

module rfirq_checker import rfirq_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_item_type rsp_payload
);

   // The back end returns to idle after each result, so strobes never come back to back.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobes in consecutive cycles");

   // A result without a successful transfer, such as a failed pop or drain or a read, returns a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.ok |-> rsp_payload.byte_out == '0)
      else $error("byte returned without a successful transfer");

   // The queue can only fill on the beat after a request is taken.
   assert property (@(posedge clock) disable iff (reset) $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted request");

   // Straight after reset the block is empty and quiet.
   assert property (@(posedge clock) $past(reset) |-> !rsp_strobe && !busy)
      else $error("activity directly after reset");

endmodule

bind register_file_w1c_irq_sio_fifo_core rfirq_checker u_checker (.*);
